### hdl/utf8_stream_validator_top_macros.svh
// assertion helpers used by utf8sv_back
`ifndef UTF8_STREAM_VALIDATOR_TOP_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define UTF8SV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define UTF8SV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define UTF8SV_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define UTF8SV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/utf8sv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utf8sv_pkg;

    // byte classes decided by the front end
    localparam logic [2:0] CLS_ASCII = 3'd0;
    localparam logic [2:0] CLS_CONT  = 3'd1;
    localparam logic [2:0] CLS_LEAD2 = 3'd2;
    localparam logic [2:0] CLS_LEAD3 = 3'd3;
    localparam logic [2:0] CLS_LEAD4 = 3'd4;
    localparam logic [2:0] CLS_BAD   = 3'd5;

    localparam int CP_W = 21;

    typedef struct packed {
        logic [2:0] cls;
        logic [5:0] bits;
        logic       last;
    } item_t;

    function automatic logic cp_ok(input logic [2:0] seq_len, input logic [CP_W-1:0] cp);
        logic ok;
        begin
            ok = 1'b1;
            if (seq_len == 3'd2 && cp < 21'h80) ok = 1'b0;
            if (seq_len == 3'd3 && cp < 21'h800) ok = 1'b0;
            if (seq_len == 3'd4 && cp < 21'h10000) ok = 1'b0;
            if (cp > 21'h10ffff) ok = 1'b0;
            if (cp >= 21'hd800 && cp <= 21'hdfff) ok = 1'b0;
            return ok;
        end
    endfunction

endpackage

`default_nettype wire

### hdl/utf8sv_front.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8sv_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,    // data_byte
    input  wire logic              s_tlast,    // last_byte
    output logic                   item_valid,
    input  wire logic              item_ready,
    output utf8sv_pkg::item_t      item
);

    logic               fv_reg;
    logic               fv_next;
    utf8sv_pkg::item_t  item_reg;
    utf8sv_pkg::item_t  item_next;
    logic               take;

    assign s_tready   = !fv_reg || item_ready;
    assign take       = s_tvalid && s_tready;
    assign item_valid = fv_reg;
    assign item       = item_reg;

    always_comb
    begin
        item_next.last = s_tlast;
        priority if (!s_tdata[7])
        begin
            item_next.cls  = utf8sv_pkg::CLS_ASCII;
            item_next.bits = s_tdata[5:0];
        end
        else if (s_tdata[7:6] == 2'b10)
        begin
            item_next.cls  = utf8sv_pkg::CLS_CONT;
            item_next.bits = s_tdata[5:0];
        end
        else if (s_tdata[7:5] == 3'b110)
        begin
            item_next.cls  = utf8sv_pkg::CLS_LEAD2;
            item_next.bits = {1'b0, s_tdata[4:0]};
        end
        else if (s_tdata[7:4] == 4'b1110)
        begin
            item_next.cls  = utf8sv_pkg::CLS_LEAD3;
            item_next.bits = {2'b0, s_tdata[3:0]};
        end
        else if (s_tdata[7:3] == 5'b11110)
        begin
            item_next.cls  = utf8sv_pkg::CLS_LEAD4;
            item_next.bits = {3'b0, s_tdata[2:0]};
        end
        else
        begin
            item_next.cls  = utf8sv_pkg::CLS_BAD;
            item_next.bits = 6'd0;
        end
    end

    always_comb
    begin
        fv_next = fv_reg;
        if (take)
            fv_next = 1'b1;
        else if (item_ready)
            fv_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else
            fv_reg <= fv_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

endmodule

`default_nettype wire

### hdl/utf8sv_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8sv_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire utf8sv_pkg::item_t push_item,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output utf8sv_pkg::item_t      pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8sv_pkg::item_t  slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slots_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

### hdl/utf8sv_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_stream_validator_top_macros.svh"

module utf8sv_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire utf8sv_pkg::item_t item,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,    // valid_so_far, message_valid, zero fill
    output logic                   m_tlast     // message_done
);

    localparam int CP_W = utf8sv_pkg::CP_W;

    logic [1:0]      pend_reg;
    logic [1:0]      pend_next;
    logic [2:0]      len_reg;
    logic [2:0]      len_next;
    logic [CP_W-1:0] cp_reg;
    logic [CP_W-1:0] cp_next;
    logic            err_reg;
    logic            err_next;
    logic            ov_reg;
    logic            ov_next;
    logic            vsf_reg;
    logic            mv_reg;
    logic            last_reg;
    logic            pop;
    logic [CP_W-1:0] cp_shift;
    logic [1:0]      pend_dec;

    assign item_ready = !ov_reg || m_tready;
    assign pop        = item_valid && item_ready;
    assign m_tvalid   = ov_reg;
    assign m_tdata    = {6'd0, mv_reg, vsf_reg};
    assign m_tlast    = last_reg;
    assign cp_shift   = {cp_reg[CP_W-7:0], item.bits};
    assign pend_dec   = pend_reg - 2'd1;

    // decode step on the popped byte, before end-of-message clearing
    always_comb
    begin
        pend_next = pend_reg;
        len_next  = len_reg;
        cp_next   = cp_reg;
        err_next  = err_reg;
        if (!err_reg)
        begin
            if (pend_reg == 2'd0)
            begin
                unique case (item.cls)
                    utf8sv_pkg::CLS_ASCII:
                    begin
                    end
                    utf8sv_pkg::CLS_LEAD2:
                    begin
                        len_next  = 3'd2;
                        pend_next = 2'd1;
                        cp_next   = {15'd0, item.bits};
                    end
                    utf8sv_pkg::CLS_LEAD3:
                    begin
                        len_next  = 3'd3;
                        pend_next = 2'd2;
                        cp_next   = {15'd0, item.bits};
                    end
                    utf8sv_pkg::CLS_LEAD4:
                    begin
                        len_next  = 3'd4;
                        pend_next = 2'd3;
                        cp_next   = {15'd0, item.bits};
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
            else if (item.cls != utf8sv_pkg::CLS_CONT)
            begin
                err_next  = 1'b1;
                pend_next = 2'd0;
                len_next  = 3'd0;
                cp_next   = '0;
            end
            else if (pend_dec != 2'd0)
            begin
                pend_next = pend_dec;
                cp_next   = cp_shift;
            end
            else
            begin
                err_next  = !utf8sv_pkg::cp_ok(len_reg, cp_shift);
                pend_next = 2'd0;
                len_next  = 3'd0;
                cp_next   = '0;
            end
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (pop)
            ov_next = 1'b1;
        else if (m_tready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            len_reg  <= 3'd0;
            cp_reg   <= '0;
            err_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            if (pop)
            begin
                if (item.last)
                begin
                    pend_reg <= 2'd0;
                    len_reg  <= 3'd0;
                    cp_reg   <= '0;
                    err_reg  <= 1'b0;
                end
                else
                begin
                    pend_reg <= pend_next;
                    len_reg  <= len_next;
                    cp_reg   <= cp_next;
                    err_reg  <= err_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            vsf_reg  <= !err_next;
            mv_reg   <= item.last && !err_next && (pend_next == 2'd0);
            last_reg <= item.last;
        end
    end

    `UTF8SV_ASSERT_SAME(a_pend_has_len, clk, rst_n, pend_reg != 2'd0, len_reg >= 3'd2)
    `UTF8SV_ASSERT_SAME(a_err_no_seq, clk, rst_n, err_reg, pend_reg == 2'd0 && len_reg == 3'd0)
    `UTF8SV_ASSERT_SAME(a_verdict_implies_clean, clk, rst_n, ov_reg && mv_reg, vsf_reg && last_reg)
    `UTF8SV_ASSERT_NEXT(a_clear_after_last, clk, rst_n, pop && item.last, pend_reg == 2'd0 && !err_reg && cp_reg == '0)

endmodule

`default_nettype wire

### hdl/utf8_stream_validator_top.sv
// strict utf-8 checker, one byte per transaction, one result per byte
// path: front item register, queue slot, then the back output register
// throughput: one byte per cycle unless m_tready stalls; decode updates per byte
// the front and back are joined by a small queue so either side may stall alone
// reset: rst_n async active low clears decode state, queue and the output valid flag
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_validator_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // data_byte
    input  wire logic       s_tlast,    // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // valid_so_far, message_valid, zero fill
    output logic            m_tlast     // message_done
);

    logic               f_valid;
    logic               f_ready;
    utf8sv_pkg::item_t  f_item;
    logic               q_valid;
    logic               q_ready;
    utf8sv_pkg::item_t  q_item;

    utf8sv_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    utf8sv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    utf8sv_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
